// ----- hdl/lct_pkg.sv -----
// Package for the LFU cache with LRU tie-break.
// Holds the payload, scan record and entry write types used by the modules.
package lct_pkg;

  localparam int IDX_W = 8;

  typedef struct packed {
    logic        kind;
    logic [31:0] key;
    logic [30:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [30:0] data_out;
    logic        evicted;
    logic [31:0] evicted_key;
  } out_item_t;

  typedef struct packed {
    logic             go;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [30:0]      hit_data;
    logic             have_free;
    logic [IDX_W-1:0] free_idx;
    logic             have_vic;
    logic [IDX_W-1:0] vic_idx;
    logic [31:0]      vic_uses;
    logic [63:0]      vic_stamp;
    logic [31:0]      vic_key;
  } scan_t;

  typedef struct packed {
    logic             en;
    logic             insert;
    logic             upd_data;
    logic [IDX_W-1:0] idx;
    logic [31:0]      key;
    logic [30:0]      data;
    logic [63:0]      stamp;
  } wr_t;

endpackage

// ----- hdl/lct_cell.sv -----
// One cache entry cell: holds one entry and updates the scan record in flight.
// Depends on lct_pkg.
module lct_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [4:0]    capacity,
  input  logic [31:0]   key,
  input  lct_pkg::scan_t scan_in,
  input  lct_pkg::wr_t  wr,
  output lct_pkg::scan_t scan_out
);
  import lct_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic        valid;
  logic [31:0] ekey;
  logic [30:0] edata;
  logic [31:0] uses;
  logic [63:0] stamp;
  logic        active;
  scan_t       scan_next;

  assign active = 32'(capacity) > 32'(IDX);

  always_comb begin
    scan_next = scan_in;
    if (scan_in.go && active) begin
      if (valid) begin
        if (!scan_in.hit && ekey == key) begin
          scan_next.hit      = 1'b1;
          scan_next.hit_idx  = MY_IDX;
          scan_next.hit_data = edata;
        end
        if (!scan_in.have_vic || uses < scan_in.vic_uses ||
            (uses == scan_in.vic_uses && stamp < scan_in.vic_stamp)) begin
          scan_next.have_vic  = 1'b1;
          scan_next.vic_idx   = MY_IDX;
          scan_next.vic_uses  = uses;
          scan_next.vic_stamp = stamp;
          scan_next.vic_key   = ekey;
        end
      end else if (!scan_in.have_free) begin
        scan_next.have_free = 1'b1;
        scan_next.free_idx  = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
      valid    <= 1'b0;
    end else begin
      scan_out <= scan_next;
      if (wr.en && wr.idx == MY_IDX) begin
        stamp <= wr.stamp;
        if (wr.insert) begin
          valid <= 1'b1;
          ekey  <= wr.key;
          edata <= wr.data;
          uses  <= 32'd1;
        end else begin
          if (uses != 32'hFFFF_FFFF) begin
            uses <= uses + 32'd1;
          end
          if (wr.upd_data) begin
            edata <= wr.data;
          end
        end
      end
    end
  end
endmodule

// ----- hdl/lct_ctrl.sv -----
// Sequencer: takes items, launches a scan down the cell chain, decides the
// entry write and holds the result. Depends on lct_pkg.
module lct_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            capacity_we,
  input  logic [4:0]      capacity,
  input  logic            in_valid,
  output logic            in_ready,
  input  lct_pkg::in_item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output lct_pkg::out_item_t out_item,
  output logic [4:0]      cap,
  output logic [31:0]     key,
  output lct_pkg::scan_t  head,
  input  lct_pkg::scan_t  tail,
  output lct_pkg::wr_t    wr
);
  import lct_pkg::*;

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t    state;
  in_item_t  item;
  logic [63:0] use_clock;
  logic      finish;
  logic      do_put;
  out_item_t res;
  scan_t     head_next;

  assign in_ready  = state == IDLE;
  assign out_valid = state == DONE;
  assign key       = item.key;
  assign finish    = state == SCAN && tail.go;
  assign do_put    = item.kind && cap != 5'd0 && !tail.hit;

  always_comb begin
    head_next    = '0;
    head_next.go = state == IDLE && in_valid;
  end

  always_comb begin
    res             = '0;
    res.found       = tail.hit;
    res.data_out    = (tail.hit && !item.kind) ? tail.hit_data : 31'd0;
    res.evicted     = do_put && !tail.have_free;
    res.evicted_key = (do_put && !tail.have_free) ? tail.vic_key : 32'd0;
    wr          = '0;
    wr.en       = finish && (tail.hit || do_put);
    wr.insert   = !tail.hit;
    wr.upd_data = item.kind;
    wr.idx      = tail.hit ? tail.hit_idx : (tail.have_free ? tail.free_idx : tail.vic_idx);
    wr.key      = item.key;
    wr.data     = item.data_in;
    wr.stamp    = use_clock;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cap       <= 5'd16;
      use_clock <= 64'd0;
      head      <= '0;
    end else begin
      head <= head_next;
      if (capacity_we) begin
        cap <= capacity;
      end
      if (wr.en) begin
        use_clock <= use_clock + 64'd1;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            item    <= in_item;
            state   <= SCAN;
          end
        end
        SCAN: begin
          if (finish) begin
            out_item <= res;
            state    <= DONE;
          end
        end
        DONE: begin
          if (out_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while a result waits");
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.evicted && out_item.found))
    else $error("eviction reported on a hit");
  a_no_data_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.evicted |-> out_item.data_out == 31'd0)
    else $error("data returned on a put");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> !wr.en)
    else $error("two entry writes for one transfer");
endmodule

// ----- hdl/lfu_cache_lru_tiebreak_top.sv -----
// LFU key/value cache with LRU tie-break, built as a chain of entry cells.
// Takes one item at a time: a new item is accepted only after the last result is taken.
// The scan record advances one cell per cycle; the entry write is broadcast at its end.
// Synchronous reset marks all entries invalid, zeroes the use clock, sets capacity 16.
module lfu_cache_lru_tiebreak_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               capacity_we,
  input  logic [4:0]         capacity,
  input  logic               in_valid,
  output logic               in_ready,
  input  lct_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output lct_pkg::out_item_t out_item
);
  import lct_pkg::*;

  scan_t       chain [MAX_ENTRIES+1];
  wr_t         wr;
  logic [4:0]  cap;
  logic [31:0] key;

  lct_ctrl u_ctrl (
    .clk, .rst, .capacity_we, .capacity, .in_valid, .in_ready, .in_item,
    .out_valid, .out_ready, .out_item, .cap, .key,
    .head(chain[0]), .tail(chain[MAX_ENTRIES]), .wr
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lct_cell #(.IDX(i)) u_cell (
      .clk, .rst, .capacity(cap), .key, .scan_in(chain[i]), .wr,
      .scan_out(chain[i+1])
    );
  end
endmodule
